// ===== sv/cfws_pkg.sv =====
// ----------------------------------------------------------------------------
// cfws_pkg: shared types and constants for the circular fifo with search
// Coordinate and pair types, request and status codes, control state.
// ----------------------------------------------------------------------------
package cfws_pkg;

   // coordinate and capacity widths fixed by the item format
   localparam int COORD_BITS    = 8;
   localparam int CAP_W         = 9;
   localparam int CNT_W         = 9;
   localparam int DEPTH_DEFAULT = 256;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   typedef logic [COORD_BITS-1:0]   coord_type;
   typedef logic [2*COORD_BITS-1:0] pair_type;

   // request codes
   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_SEARCH = 2'd2
   } req_code_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // control sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_WALK = 1'b1
   } fsm_state_type;

   // slot write broadcast to the cell row
   typedef struct packed {
      logic     we;
      pair_type wdata;
   } slot_wr_type;

endpackage

// ===== sv/cfws_req_if.sv =====
// ----------------------------------------------------------------------------
// cfws_req_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface cfws_req_if;
   import cfws_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   coord_type  row_in;
   coord_type  column_in;

   modport source (output valid, output req_type, output row_in, output column_in,
                   input ready);
   modport sink   (input valid, input req_type, input row_in, input column_in,
                   output ready);
endinterface

// ===== sv/cfws_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cfws_rsp_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface cfws_rsp_if;
   import cfws_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       status;
   coord_type        row_out;
   coord_type        column_out;
   logic             found;
   logic             head_valid;
   logic [CNT_W-1:0] count;

   modport source (output valid, output status, output row_out, output column_out,
                   output found, output head_valid, output count, input ready);
   modport sink   (input valid, input status, input row_out, input column_out,
                   input found, input head_valid, input count, output ready);
endinterface

// ===== sv/cfws_cell.sv =====
// ----------------------------------------------------------------------------
// cfws_cell: one queue slot of the cell row
// Holds one pair, matches it against the search key when the slot lies on
// the occupied walk, and passes a hit bit and a read word to its neighbor.
// ----------------------------------------------------------------------------
module cfws_cell #(
   parameter int AW = 8,
   parameter int CW = 10
) (
   input  logic                  clock,
   input  logic [AW-1:0]         slot_idx,
   input  cfws_pkg::slot_wr_type wr,
   input  logic [AW-1:0]         wr_addr,
   input  cfws_pkg::pair_type    key,
   input  logic [CW-1:0]         a_lo,
   input  logic [CW-1:0]         a_hi,
   input  logic [CW-1:0]         b_hi,
   input  logic [AW-1:0]         rd_addr,
   input  logic                  hit_prev,
   input  cfws_pkg::pair_type    rd_prev,
   output logic                  hit_next,
   output cfws_pkg::pair_type    rd_next
);
   import cfws_pkg::*;

   pair_type      data_ff;
   logic          hit_ff;
   pair_type      rd_ff;
   logic [CW-1:0] idx_w;
   logic          on_walk;

   // slot lies in the wrapped range of occupied entries
   always_comb begin
      idx_w   = CW'(slot_idx);
      on_walk = ((idx_w >= a_lo) && (idx_w < a_hi)) || (idx_w < b_hi);
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (wr.we && (wr_addr == slot_idx)) begin
         data_ff <= wr.wdata;
      end
   end

   // hit and read words move one cell per cycle
   always_ff @(posedge clock) begin
      hit_ff <= hit_prev | (on_walk & (data_ff == key));
      rd_ff  <= (rd_addr == slot_idx) ? data_ff : rd_prev;
   end

   assign hit_next = hit_ff;
   assign rd_next  = rd_ff;

endmodule

// ===== sv/circular_fifo_with_search.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_search: circular fifo of coordinate pairs with search
// Push, pop and membership search over a ring of QUEUE_DEPTH cells.
// Push and unused codes load their result into the result register on accept.
// Pop loads its result on accept; if entries remain, the new head pair is read
//   through the cell row, and no next item is taken until that pass ends.
// Search: result loaded at the end of the pass, set by the hit bit rippling
//   through the QUEUE_DEPTH cells, one cell per cycle; one item at a time.
// Reset clears pointers, count and control, and sets the capacity to 256;
//   slot contents are not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_with_search #(
   parameter int QUEUE_DEPTH = cfws_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [cfws_pkg::CAP_W-1:0] csr_wdata,
   cfws_req_if.sink                   req_ch,
   cfws_rsp_if.source                 rsp_ch
);
   import cfws_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = (AW + 1 > CAP_W + 1) ? AW + 1 : CAP_W + 1;
   localparam int WCW = AW + 1;

   // step one slot, wrapping at the active capacity
   function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] p,
                                               input logic [CW-1:0] cap);
      logic [CW-1:0] n;
      n = CW'(p) + CW'(1);
      return (n >= cap) ? '0 : n[AW-1:0];
   endfunction

   // control and state registers
   fsm_state_type    state_ff, state_in;
   logic [CAP_W-1:0] cap_ff;
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   pair_type         head_pair_ff, head_pair_in;
   logic [WCW-1:0]   walk_cnt_ff;
   logic             walk_pop_ff, walk_pop_in;

   // walk setup registers
   pair_type         key_ff, key_in;
   logic [CW-1:0]    a_lo_ff, a_lo_in;
   logic [CW-1:0]    a_hi_ff, a_hi_in;
   logic [CW-1:0]    b_hi_ff, b_hi_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in;

   // result register
   logic             rsp_vld_ff;
   status_type       rsp_status_ff, rsp_status_in;
   pair_type         rsp_pair_ff, rsp_pair_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0] rsp_cnt_ff;

   logic             req_ready;
   logic             in_walk;
   logic             accept;
   logic             walk_done;
   logic             start_walk;
   logic             rsp_load;
   logic             pop_ok;
   pair_type         key_now;
   logic [CW-1:0]    cap_w, cap_eff, h_w, n_w, e_w;
   slot_wr_type      wr;
   logic [AW-1:0]    wr_addr;

   logic             hit_chain [QUEUE_DEPTH+1];
   pair_type         rd_chain  [QUEUE_DEPTH+1];

   // active capacity clamped to one .. QUEUE_DEPTH
   always_comb begin
      cap_w = CW'(cap_ff);
      if (cap_w == '0) begin
         cap_eff = CW'(1);
      end else if (cap_w > CW'(QUEUE_DEPTH)) begin
         cap_eff = CW'(QUEUE_DEPTH);
      end else begin
         cap_eff = cap_w;
      end
      h_w = CW'(head_ff);
      n_w = CW'(cnt_ff);
      e_w = h_w + n_w;
   end

   assign key_now   = {req_ch.row_in, req_ch.column_in};
   assign accept    = req_ch.valid && req_ready;
   assign walk_done = in_walk && (walk_cnt_ff == WCW'(QUEUE_DEPTH));

   // request decode and next state of the queue
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      head_pair_in  = head_pair_ff;
      walk_pop_in   = walk_pop_ff;
      key_in        = key_ff;
      a_lo_in       = a_lo_ff;
      a_hi_in       = a_hi_ff;
      b_hi_in       = b_hi_ff;
      rd_addr_in    = rd_addr_ff;
      wr.we         = 1'b0;
      wr.wdata      = key_now;
      wr_addr       = tail_ff;
      start_walk    = 1'b0;
      rsp_load      = 1'b0;
      pop_ok        = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_found_in  = 1'b0;
      rsp_pair_in   = '0;

      if (accept) begin
         rsp_load = 1'b1;
         case (req_code_type'(req_ch.req_type))
            REQ_PUSH: begin
               if (n_w >= cap_eff) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  wr.we  = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (cnt_ff == '0) begin
                     head_in      = '0;
                     tail_in      = '0;
                     wr_addr      = '0;
                     head_pair_in = key_now;
                  end else begin
                     tail_in = step_slot(tail_ff, cap_eff);
                     wr_addr = tail_in;
                     // a push landing on the head slot replaces the head pair
                     if (tail_in == head_ff) begin
                        head_pair_in = key_now;
                     end
                  end
               end
            end
            REQ_POP: begin
               if (cnt_ff == '0) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  pop_ok = 1'b1;
                  cnt_in = cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     // fetch the new head pair through the cell row
                     head_in     = step_slot(head_ff, cap_eff);
                     rd_addr_in  = head_in;
                     walk_pop_in = 1'b1;
                     start_walk  = 1'b1;
                  end
               end
            end
            REQ_SEARCH: begin
               rsp_load    = 1'b0;
               start_walk  = 1'b1;
               walk_pop_in = 1'b0;
               key_in      = key_now;
               rd_addr_in  = head_ff;
               a_lo_in     = h_w;
               // occupied slots as one range from head plus a wrapped range from 0
               if (n_w == '0) begin
                  a_hi_in = h_w;
                  b_hi_in = '0;
               end else if (h_w < cap_eff) begin
                  a_hi_in = (e_w < cap_eff) ? e_w : cap_eff;
                  if (e_w > cap_eff) begin
                     b_hi_in = ((e_w - cap_eff) < cap_eff) ? (e_w - cap_eff) : cap_eff;
                  end else begin
                     b_hi_in = '0;
                  end
               end else begin
                  // head left beyond a reduced capacity
                  a_hi_in = h_w + CW'(1);
                  b_hi_in = ((n_w - CW'(1)) < cap_eff) ? (n_w - CW'(1)) : cap_eff;
               end
            end
            default: begin
               rsp_status_in = STAT_OK;
            end
         endcase
         if (pop_ok) begin
            rsp_pair_in = head_pair_ff;
         end else if (cnt_in != '0) begin
            rsp_pair_in = head_pair_in;
         end
      end

      // end of a pass through the cell row
      if (walk_done) begin
         if (walk_pop_ff) begin
            head_pair_in = rd_chain[QUEUE_DEPTH];
         end else begin
            rsp_load     = 1'b1;
            rsp_found_in = hit_chain[QUEUE_DEPTH];
            rsp_pair_in  = (cnt_ff != '0) ? head_pair_ff : '0;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && start_walk) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      in_walk   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_vld_ff || rsp_ch.ready;
         end
         S_WALK: begin
            in_walk = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cap_ff      <= CAP_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         cnt_ff      <= '0;
         walk_cnt_ff <= '0;
         walk_pop_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         cnt_ff      <= cnt_in;
         walk_pop_ff <= walk_pop_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (accept && start_walk) begin
            walk_cnt_ff <= '0;
         end else if (in_walk) begin
            walk_cnt_ff <= walk_cnt_ff + WCW'(1);
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_pair_ff <= head_pair_in;
      key_ff       <= key_in;
      a_lo_ff      <= a_lo_in;
      a_hi_ff      <= a_hi_in;
      b_hi_ff      <= b_hi_in;
      rd_addr_ff   <= rd_addr_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pair_ff   <= rsp_pair_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_cnt_ff    <= cnt_in;
      end
   end

   // row of slot cells
   assign hit_chain[0] = 1'b0;
   assign rd_chain[0]  = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cfws_cell #(
         .AW (AW),
         .CW (CW)
      ) u_cell (
         .clock    (clock),
         .slot_idx (AW'(i)),
         .wr       (wr),
         .wr_addr  (wr_addr),
         .key      (key_ff),
         .a_lo     (a_lo_ff),
         .a_hi     (a_hi_ff),
         .b_hi     (b_hi_ff),
         .rd_addr  (rd_addr_ff),
         .hit_prev (hit_chain[i]),
         .rd_prev  (rd_chain[i]),
         .hit_next (hit_chain[i+1]),
         .rd_next  (rd_chain[i+1])
      );
   end

   // result channel
   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.row_out    = rsp_pair_ff[2*COORD_BITS-1:COORD_BITS];
   assign rsp_ch.column_out = rsp_pair_ff[COORD_BITS-1:0];
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.head_valid = (rsp_cnt_ff != '0);
   assign rsp_ch.count      = rsp_cnt_ff;

   // an empty queue keeps both pointers at slot zero
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> ((head_ff == '0) && (tail_ff == '0)))
      else $error("pointers not at slot zero while empty");

   // the count never exceeds the ring size
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      CW'(cnt_ff) <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond ring size");

   // a result is never loaded over one that has not been taken
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_vld_ff || rsp_ch.ready))
      else $error("result register overwritten");

   // no item is taken while a pass through the cell row is running
   a_walk_block: assert property (@(posedge clock) disable iff (reset)
      in_walk |-> !req_ready)
      else $error("request taken during cell row pass");

   // the pass counter never skips a step during a pass
   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      (in_walk && !walk_done) |=> (walk_cnt_ff == $past(walk_cnt_ff) + WCW'(1)))
      else $error("cell row pass counter skipped");

endmodule
